/* sv/card_marking_write_barrier_defines.svh */
// assertion macros shared by the write barrier rtl
`ifndef CARD_MARKING_WRITE_BARRIER_DEFINES_SVH
`define CARD_MARKING_WRITE_BARRIER_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define CMWB_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define CMWB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/cmwb_pkg.sv */
// types, codes and helpers for the card marking write barrier
`timescale 1ns / 1ps

package cmwb_pkg;

   // command codes carried in func
   localparam logic [2:0] FUNC_WRITE       = 3'd0;
   localparam logic [2:0] FUNC_READ        = 3'd1;
   localparam logic [2:0] FUNC_PROBE       = 3'd2;
   localparam logic [2:0] FUNC_CLEAR       = 3'd3;
   localparam logic [2:0] FUNC_RESET_STATS = 3'd4;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 13;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_ENABLED   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CARDS_IN_USE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_CARD_BYTES = 2'd2;

   // sequencer states, one-hot
   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } cmwb_state_type;

   // one accepted request item
   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] object_address;
      logic        object_present;
      logic        object_old;
      logic        value_present;
      logic        value_old;
      logic [31:0] owner_id;
      logic        object_shared;
      logic [31:0] accessor_id;
      logic        last_in_group;
      logic [11:0] card_number;
   } cmwb_item_type;

   // saturating increment for the statistics counters
   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

endpackage

/* sv/card_marking_write_barrier.sv */
// card marking write barrier: path classification, card store and counters
//
//  channel   ports            direction  carries
//  req       req_valid/ready  in         one barrier command item
//  rsp       rsp_valid/ready  out        path, mark and probe flags, counters
//  csr       csr_valid/ready  in         register index and write data
//
// an item passes through accept (card store read issued) and execute
// (store written back, result registered); the store read is registered.
// a finished item waits in execute while the previous result is not taken.
// after reset, a clear command while enabled or an enable write from off, the store
// is swept one card a cycle over all NUM_CARDS cards, while no item is accepted.
// CARD_BYTES must be a power of two, which the block does not check; card index is the address shifted down.
`timescale 1ns / 1ps

module card_marking_write_barrier #(
   parameter int unsigned CARD_BYTES = 512,
   parameter int unsigned NUM_CARDS  = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [2:0]                       req_func,
   input  logic [31:0]                      req_object_address,
   input  logic                             req_object_present,
   input  logic                             req_object_old,
   input  logic                             req_value_present,
   input  logic                             req_value_old,
   input  logic [31:0]                      req_owner_id,
   input  logic                             req_object_shared,
   input  logic [31:0]                      req_accessor_id,
   input  logic                             req_last_in_group,
   input  logic [11:0]                      req_card_number,
   // configuration channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cmwb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cmwb_pkg::CSR_DATA_W-1:0]  csr_data,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_sync_path,
   output logic                             rsp_card_marked,
   output logic                             rsp_card_dirty,
   output logic [20:0]                      rsp_card_base,
   output logic [9:0]                       rsp_card_length,
   output logic [31:0]                      rsp_fast_count,
   output logic [31:0]                      rsp_sync_count,
   output logic [31:0]                      rsp_hit_count,
   output logic [31:0]                      rsp_mark_count
);

   localparam int unsigned CARD_SHIFT = $clog2(CARD_BYTES);
   localparam int unsigned IDX_W      = $clog2(NUM_CARDS);
   localparam logic [32:0] CARD_LEN   = 33'(CARD_BYTES);
   localparam logic [32:0] CARD_MAX   = 33'(NUM_CARDS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CARDS - 1);

   // control state
   cmwb_pkg::cmwb_state_type state_ff, state_in;
   logic [IDX_W-1:0]  clr_ptr_ff, clr_ptr_in;
   logic              table_enabled_ff;
   logic [12:0]       cards_in_use_ff;
   logic [9:0]        last_card_bytes_ff;
   logic [31:0]       fast_total_ff, fast_total_in;
   logic [31:0]       sync_total_ff, sync_total_in;
   logic [31:0]       hit_total_ff, hit_total_in;
   logic [31:0]       mark_total_ff, mark_total_in;
   logic              group_mark_ff, group_mark_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload registers
   cmwb_pkg::cmwb_item_type item_ff;
   logic              card_rd_ff;
   logic              sync_path_ff, sync_path_in;
   logic              card_marked_ff, card_marked_in;
   logic              card_dirty_ff, card_dirty_in;
   logic [20:0]       card_base_ff, card_base_in;
   logic [9:0]        card_length_ff, card_length_in;

   // card store
   logic              card_mem [NUM_CARDS];
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic              mem_wdata;
   logic [IDX_W-1:0]  mem_raddr;

   logic              req_fire;
   logic              csr_fire;
   logic              enable_rise;
   logic              exec_done;
   logic              clear_now;
   logic              mark_now;
   logic              cross_task;
   logic              group_need;
   logic              mark_in_range;
   logic              probe_ok;
   logic [32:0]       live_cards;
   logic [32:0]       mark_idx;
   logic [32:0]       cardn_ext;
   logic [32:0]       start_wide;
   logic [32:0]       last_len;

   // handshakes
   assign req_ready   = (state_ff == cmwb_pkg::ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign csr_ready   = 1'b1;
   assign csr_fire    = csr_valid;
   assign enable_rise = csr_fire && (csr_index == cmwb_pkg::CSR_TABLE_ENABLED)
                        && csr_data[0] && !table_enabled_ff;
   assign exec_done   = (state_ff == cmwb_pkg::ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   // card arithmetic on the held item
   assign live_cards    = (33'(cards_in_use_ff) > CARD_MAX) ? CARD_MAX
                                                            : 33'(cards_in_use_ff);
   assign mark_idx      = 33'(item_ff.object_address >> CARD_SHIFT);
   assign mark_in_range = table_enabled_ff && (mark_idx < live_cards);
   assign cardn_ext     = 33'(item_ff.card_number);
   assign probe_ok      = table_enabled_ff && (cardn_ext < live_cards);
   assign start_wide    = cardn_ext << CARD_SHIFT;
   assign last_len      = (33'(last_card_bytes_ff) > CARD_LEN) ? CARD_LEN
                                                               : 33'(last_card_bytes_ff);
   assign cross_task    = (item_ff.owner_id != item_ff.accessor_id) || item_ff.object_shared;
   assign group_need    = group_mark_ff
                          || (item_ff.object_old && item_ff.value_present
                              && !item_ff.value_old);

   // execute step: counters, group flag and result fields
   always_comb begin
      fast_total_in  = fast_total_ff;
      sync_total_in  = sync_total_ff;
      hit_total_in   = hit_total_ff;
      mark_total_in  = mark_total_ff;
      group_mark_in  = group_mark_ff;
      sync_path_in   = 1'b0;
      card_marked_in = 1'b0;
      card_dirty_in  = 1'b0;
      card_base_in   = '0;
      card_length_in = '0;
      mark_now       = 1'b0;
      clear_now      = 1'b0;
      if (exec_done) begin
         unique case (item_ff.func)
            cmwb_pkg::FUNC_WRITE: begin
               if (!item_ff.object_present) begin
                  if (item_ff.last_in_group) begin
                     group_mark_in = 1'b0;
                  end
               end else begin
                  sync_path_in = cross_task;
                  if (cross_task) begin
                     sync_total_in = cmwb_pkg::sat_inc(sync_total_ff);
                  end else begin
                     fast_total_in = cmwb_pkg::sat_inc(fast_total_ff);
                  end
                  group_mark_in = item_ff.last_in_group ? 1'b0 : group_need;
                  if (item_ff.last_in_group && group_need) begin
                     hit_total_in = cmwb_pkg::sat_inc(hit_total_ff);
                     if (mark_in_range) begin
                        mark_now       = 1'b1;
                        card_marked_in = 1'b1;
                        mark_total_in  = cmwb_pkg::sat_inc(mark_total_ff);
                     end
                  end
               end
            end
            cmwb_pkg::FUNC_READ: begin
               sync_path_in = item_ff.object_present && cross_task;
            end
            cmwb_pkg::FUNC_PROBE: begin
               if (probe_ok) begin
                  card_dirty_in  = card_rd_ff;
                  card_base_in   = start_wide[20:0];
                  card_length_in = (cardn_ext == live_cards - 33'd1) ? last_len[9:0]
                                                                     : CARD_LEN[9:0];
               end
            end
            cmwb_pkg::FUNC_CLEAR: begin
               clear_now = table_enabled_ff;
            end
            cmwb_pkg::FUNC_RESET_STATS: begin
               fast_total_in = '0;
               sync_total_in = '0;
               hit_total_in  = '0;
               mark_total_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer and clearing sweep
   always_comb begin
      state_in   = state_ff;
      clr_ptr_in = clr_ptr_ff;
      if (enable_rise) begin
         state_in   = cmwb_pkg::ST_CLEAR;
         clr_ptr_in = '0;
      end else begin
         unique case (state_ff)
            cmwb_pkg::ST_CLEAR: begin
               clr_ptr_in = clr_ptr_ff + IDX_W'(1);
               if (clr_ptr_ff == LAST_IDX) begin
                  state_in = cmwb_pkg::ST_IDLE;
               end
            end
            cmwb_pkg::ST_IDLE: begin
               if (req_fire) begin
                  state_in = cmwb_pkg::ST_EXEC;
               end
            end
            cmwb_pkg::ST_EXEC: begin
               if (exec_done) begin
                  state_in   = clear_now ? cmwb_pkg::ST_CLEAR : cmwb_pkg::ST_IDLE;
                  clr_ptr_in = '0;
               end
            end
            default: begin
               state_in = cmwb_pkg::ST_CLEAR;
            end
         endcase
      end
   end

   // result slot
   assign rsp_valid_in = exec_done ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= cmwb_pkg::ST_CLEAR;
         clr_ptr_ff         <= '0;
         table_enabled_ff   <= 1'b0;
         cards_in_use_ff    <= 13'(NUM_CARDS);
         last_card_bytes_ff <= 10'(CARD_BYTES);
         fast_total_ff      <= '0;
         sync_total_ff      <= '0;
         hit_total_ff       <= '0;
         mark_total_ff      <= '0;
         group_mark_ff      <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ptr_ff    <= clr_ptr_in;
         fast_total_ff <= fast_total_in;
         sync_total_ff <= sync_total_in;
         hit_total_ff  <= hit_total_in;
         mark_total_ff <= mark_total_in;
         group_mark_ff <= group_mark_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_fire) begin
            unique case (csr_index)
               cmwb_pkg::CSR_TABLE_ENABLED:   table_enabled_ff   <= csr_data[0];
               cmwb_pkg::CSR_CARDS_IN_USE:    cards_in_use_ff    <= csr_data[12:0];
               cmwb_pkg::CSR_LAST_CARD_BYTES: last_card_bytes_ff <= csr_data[9:0];
               default: begin
               end
            endcase
         end
      end
   end

   // item capture and result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= '{func:           req_func,
                      object_address: req_object_address,
                      object_present: req_object_present,
                      object_old:     req_object_old,
                      value_present:  req_value_present,
                      value_old:      req_value_old,
                      owner_id:       req_owner_id,
                      object_shared:  req_object_shared,
                      accessor_id:    req_accessor_id,
                      last_in_group:  req_last_in_group,
                      card_number:    req_card_number};
      end
      if (exec_done) begin
         sync_path_ff   <= sync_path_in;
         card_marked_ff <= card_marked_in;
         card_dirty_ff  <= card_dirty_in;
         card_base_ff   <= card_base_in;
         card_length_ff <= card_length_in;
      end
   end

   // card store ports: sweep or mark write, read on every accept for the probe
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_ptr_ff;
      mem_wdata = 1'b0;
      if (state_ff == cmwb_pkg::ST_CLEAR) begin
         mem_we = 1'b1;
      end else if (mark_now) begin
         mem_we    = 1'b1;
         mem_waddr = mark_idx[IDX_W-1:0];
         mem_wdata = 1'b1;
      end
   end

   assign mem_raddr = IDX_W'(req_card_number);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         card_mem[mem_waddr] <= mem_wdata;
      end
      if (req_fire) begin
         card_rd_ff <= card_mem[mem_raddr];
      end
   end

   // outputs; counters hold until the next item completes
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sync_path   = sync_path_ff;
   assign rsp_card_marked = card_marked_ff;
   assign rsp_card_dirty  = card_dirty_ff;
   assign rsp_card_base   = card_base_ff;
   assign rsp_card_length = card_length_ff;
   assign rsp_fast_count  = fast_total_ff;
   assign rsp_sync_count  = sync_total_ff;
   assign rsp_hit_count   = hit_total_ff;
   assign rsp_mark_count  = mark_total_ff;

   // checks
`include "card_marking_write_barrier_defines.svh"

   `CMWB_ASSERT_SAME(a_mark_write_legal, mem_we && mem_wdata,
      (state_ff == cmwb_pkg::ST_EXEC) && mark_in_range, "card mark outside execute or range")
   `CMWB_ASSERT_SAME(a_rsp_from_exec, $rose(rsp_valid_ff),
      $past(state_ff == cmwb_pkg::ST_EXEC), "result appeared without an executed item")
   `CMWB_ASSERT_SAME(a_marked_counted, rsp_valid_ff && card_marked_ff,
      (mark_total_ff != 32'd0) && (hit_total_ff != 32'd0), "marked item without counts")
   `CMWB_ASSERT_NEXT(a_fast_monotonic,
      exec_done && (item_ff.func != cmwb_pkg::FUNC_RESET_STATS),
      fast_total_ff >= $past(fast_total_ff), "fast counter went down")
   `CMWB_ASSERT_NEXT(a_sweep_ends,
      (state_ff == cmwb_pkg::ST_CLEAR) && (clr_ptr_ff == LAST_IDX) && !enable_rise,
      state_ff == cmwb_pkg::ST_IDLE, "clearing sweep did not end")

endmodule
